[hdl/ebbp_pkg.sv]
// Shared types and constants for the EDID base block parser.
// No dependencies; used by every module under hdl/.
package ebbp_pkg;

  // Layout of the 128-byte base block
  localparam int unsigned PosW      = 7;
  localparam int unsigned DescOffW  = 5;
  localparam int unsigned TextCntW  = 4;

  localparam logic [PosW-1:0] PosMfgHi    = 7'd8;
  localparam logic [PosW-1:0] PosMfgLo    = 7'd9;
  localparam logic [PosW-1:0] PosModelYr  = 7'd16;
  localparam logic [PosW-1:0] PosYear     = 7'd17;
  localparam logic [PosW-1:0] PosMajor    = 7'd18;
  localparam logic [PosW-1:0] PosMinor    = 7'd19;
  localparam logic [PosW-1:0] PosDescLo   = 7'd54;
  localparam logic [PosW-1:0] PosDescEnd  = 7'd126;  // 54 + 4 * 18
  localparam logic [PosW-1:0] PosLast     = 7'd127;

  // Offsets within one 18-byte descriptor
  localparam logic [DescOffW-1:0] OffHdr0    = 5'd0;
  localparam logic [DescOffW-1:0] OffHdr1    = 5'd1;
  localparam logic [DescOffW-1:0] OffHdr2    = 5'd2;
  localparam logic [DescOffW-1:0] OffTag     = 5'd3;
  localparam logic [DescOffW-1:0] OffText    = 5'd5;
  localparam logic [DescOffW-1:0] OffDescMax = 5'd17;

  localparam logic [TextCntW-1:0] TextMax = 4'd13;

  localparam logic [7:0] TagModel  = 8'hFC;
  localparam logic [7:0] TagSerial = 8'hFF;
  localparam logic [7:0] TextTerm  = 8'h0A;
  localparam logic [7:0] ByteFF    = 8'hFF;

  localparam logic [11:0] YearBase = 12'd1990;

  // Result kinds
  localparam logic [1:0] KindModel   = 2'd0;
  localparam logic [1:0] KindSerial  = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  // Operation the back end carries out for one byte
  typedef enum logic [3:0] {
    OP_SUM,
    OP_MFG_HI,
    OP_MFG_LO,
    OP_MODEL_YR,
    OP_YEAR,
    OP_MAJOR,
    OP_MINOR,
    OP_TEXT,
    OP_SUMMARY
  } op_t;

  // One classified byte, front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] raw;     // byte as received, for sum and captures
    logic [7:0] text;    // text character, 0 on terminator marker
    logic       slot;    // 0 model name, 1 serial
    logic       last;    // end of text string
    logic       names;   // both descriptor kinds seen in this block
  } entry_t;

endpackage

[hdl/ebbp_front.sv]
// Front end: byte position tracking and descriptor decode.
// Classifies every byte into an ebbp_pkg::entry_t. Depends on ebbp_pkg.
module ebbp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        edid_byte,
  output ebbp_pkg::entry_t  entry
);

  logic [ebbp_pkg::PosW-1:0]     pos, pos_next;
  logic [ebbp_pkg::DescOffW-1:0] desc_off, desc_off_next;
  logic [ebbp_pkg::TextCntW-1:0] text_count, text_count_next;
  logic header_match, header_match_next;
  logic text_slot, text_slot_next;
  logic text_active, text_active_next;
  logic model_seen, model_seen_next;
  logic serial_seen, serial_seen_next;
  logic in_desc;

  assign in_desc = (pos >= ebbp_pkg::PosDescLo) && (pos < ebbp_pkg::PosDescEnd);

  always_comb begin
    pos_next          = pos + 1'b1;
    desc_off_next     = desc_off;
    text_count_next   = text_count;
    header_match_next = header_match;
    text_slot_next    = text_slot;
    text_active_next  = text_active;
    model_seen_next   = model_seen;
    serial_seen_next  = serial_seen;

    entry.op    = ebbp_pkg::OP_SUM;
    entry.raw   = edid_byte;
    entry.text  = edid_byte;
    entry.slot  = text_slot;
    entry.last  = 1'b0;
    entry.names = model_seen && serial_seen;

    case (pos)
      ebbp_pkg::PosMfgHi:   entry.op = ebbp_pkg::OP_MFG_HI;
      ebbp_pkg::PosMfgLo:   entry.op = ebbp_pkg::OP_MFG_LO;
      ebbp_pkg::PosModelYr: entry.op = ebbp_pkg::OP_MODEL_YR;
      ebbp_pkg::PosYear:    entry.op = ebbp_pkg::OP_YEAR;
      ebbp_pkg::PosMajor:   entry.op = ebbp_pkg::OP_MAJOR;
      ebbp_pkg::PosMinor:   entry.op = ebbp_pkg::OP_MINOR;
      default: ;
    endcase

    if (in_desc) begin
      desc_off_next = (desc_off == ebbp_pkg::OffDescMax) ? '0 : desc_off + 1'b1;
      case (desc_off)
        ebbp_pkg::OffHdr0: begin
          header_match_next = (edid_byte == 8'h00);
          text_active_next  = 1'b0;
        end
        ebbp_pkg::OffHdr1, ebbp_pkg::OffHdr2: begin
          header_match_next = header_match && (edid_byte == 8'h00);
        end
        ebbp_pkg::OffTag: begin
          if (header_match && (edid_byte == ebbp_pkg::TagModel ||
                               edid_byte == ebbp_pkg::TagSerial)) begin
            text_slot_next   = (edid_byte == ebbp_pkg::TagSerial);
            text_active_next = 1'b1;
            text_count_next  = '0;
            if (edid_byte == ebbp_pkg::TagSerial) begin
              serial_seen_next = 1'b1;
            end else begin
              model_seen_next = 1'b1;
            end
          end else begin
            text_active_next = 1'b0;
          end
        end
        default: begin
          if (desc_off >= ebbp_pkg::OffText && text_active) begin
            entry.op = ebbp_pkg::OP_TEXT;
            if (edid_byte == ebbp_pkg::TextTerm) begin
              entry.text       = 8'h00;
              entry.last       = 1'b1;
              text_active_next = 1'b0;
            end else begin
              text_count_next = text_count + 1'b1;
              if (text_count_next >= ebbp_pkg::TextMax) begin
                entry.last       = 1'b1;
                text_active_next = 1'b0;
              end
            end
          end
        end
      endcase
    end

    if (pos == ebbp_pkg::PosLast) begin
      entry.op         = ebbp_pkg::OP_SUMMARY;
      model_seen_next  = 1'b0;
      serial_seen_next = 1'b0;
      text_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      desc_off     <= '0;
      text_count   <= '0;
      header_match <= 1'b1;
      text_slot    <= 1'b0;
      text_active  <= 1'b0;
      model_seen   <= 1'b0;
      serial_seen  <= 1'b0;
    end else if (accept) begin
      pos          <= pos_next;
      desc_off     <= desc_off_next;
      text_count   <= text_count_next;
      header_match <= header_match_next;
      text_slot    <= text_slot_next;
      text_active  <= text_active_next;
      model_seen   <= model_seen_next;
      serial_seen  <= serial_seen_next;
    end
  end

endmodule

[hdl/ebbp_queue.sv]
// Two-entry queue of classified bytes between front and back.
// Depends on ebbp_pkg for entry_t.
module ebbp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ebbp_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output ebbp_pkg::entry_t  head
);

  ebbp_pkg::entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

[hdl/ebbp_back.sv]
// Back end: checksum, identity field capture and result output register.
// Consumes one ebbp_pkg::entry_t per cycle from the queue unless stalled.
module ebbp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  ebbp_pkg::entry_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        result_kind,
  output logic [7:0]        text_byte,
  output logic              text_last,
  output logic [7:0]        checksum_sum,
  output logic [6:0]        mfg_first,
  output logic [6:0]        mfg_second,
  output logic [6:0]        mfg_third,
  output logic [11:0]       year,
  output logic              model_year,
  output logic [7:0]        version_major,
  output logic [7:0]        version_minor,
  output logic              names_found
);

  logic [7:0] running_sum, sum_next;
  logic [7:0] mfg_high_byte, mfg_low_byte, year_byte, major_byte, minor_byte;
  logic       model_year_flag;
  logic       emits;

  assign pop      = avail && (!out_valid || out_ready);
  assign sum_next = running_sum + head.raw;
  assign emits    = (head.op == ebbp_pkg::OP_TEXT) || (head.op == ebbp_pkg::OP_SUMMARY);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      mfg_high_byte   <= '0;
      mfg_low_byte    <= '0;
      year_byte       <= '0;
      model_year_flag <= 1'b0;
      major_byte      <= '0;
      minor_byte      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        // summary closes the block, so the sum restarts
        running_sum <= (head.op == ebbp_pkg::OP_SUMMARY) ? '0 : sum_next;
        case (head.op)
          ebbp_pkg::OP_MFG_HI:   mfg_high_byte   <= head.raw;
          ebbp_pkg::OP_MFG_LO:   mfg_low_byte    <= head.raw;
          ebbp_pkg::OP_MODEL_YR: model_year_flag <= (head.raw == ebbp_pkg::ByteFF);
          ebbp_pkg::OP_YEAR:     year_byte       <= head.raw;
          ebbp_pkg::OP_MAJOR:    major_byte      <= head.raw;
          ebbp_pkg::OP_MINOR:    minor_byte      <= head.raw;
          default: ;
        endcase
        // pop implies the output register is empty or being drained now
        out_valid <= emits;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop && emits) begin
      if (head.op == ebbp_pkg::OP_SUMMARY) begin
        result_kind   <= ebbp_pkg::KindSummary;
        text_byte     <= '0;
        text_last     <= 1'b0;
        checksum_sum  <= sum_next;
        mfg_first     <= {2'b10, mfg_high_byte[6:2]};
        mfg_second    <= {2'b10, mfg_high_byte[1:0], mfg_low_byte[7:5]};
        mfg_third     <= {2'b10, mfg_low_byte[4:0]};
        year          <= {4'b0, year_byte} + ebbp_pkg::YearBase;
        model_year    <= model_year_flag;
        version_major <= major_byte;
        version_minor <= minor_byte;
        names_found   <= head.names;
      end else begin
        result_kind   <= head.slot ? ebbp_pkg::KindSerial : ebbp_pkg::KindModel;
        text_byte     <= head.text;
        text_last     <= head.last;
        checksum_sum  <= '0;
        mfg_first     <= '0;
        mfg_second    <= '0;
        mfg_third     <= '0;
        year          <= '0;
        model_year    <= 1'b0;
        version_major <= '0;
        version_minor <= '0;
        names_found   <= 1'b0;
      end
    end
  end

endmodule

[hdl/edid_base_block_parser_core.sv]
// Top level of the EDID base block parser: front decode, queue, back end.
// Depends on ebbp_pkg, ebbp_front, ebbp_queue, ebbp_back.
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ------------------------------
//   input     in         in_valid / in_ready    edid_byte
//   result    out        out_valid / out_ready  result_kind .. names_found
//
// One byte per cycle sustained while results are taken. A byte passes front
// decode in the cycle it is transferred, is written into the two-entry queue
// and lands in the output register when it is popped. Synchronous reset clears
// the position counter, descriptor state, checksum and all valid flags. A
// stalled result holds the back end only; the front keeps taking bytes until
// the queue is full, after which in_ready drops.
module edid_base_block_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  edid_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  text_byte,
  output logic        text_last,
  output logic [7:0]  checksum_sum,
  output logic [6:0]  mfg_first,
  output logic [6:0]  mfg_second,
  output logic [6:0]  mfg_third,
  output logic [11:0] year,
  output logic        model_year,
  output logic [7:0]  version_major,
  output logic [7:0]  version_minor,
  output logic        names_found
);

  ebbp_pkg::entry_t front_entry;
  ebbp_pkg::entry_t queue_head;
  logic             in_xfer;
  logic             q_full, q_avail, q_pop;

  // Ready depends only on queue fill, never on the output side directly.
  assign in_ready = !q_full;
  assign in_xfer  = in_valid && in_ready;

  ebbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_xfer),
    .edid_byte (edid_byte),
    .entry     (front_entry)
  );

  ebbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_xfer),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_avail),
    .head       (queue_head)
  );

  ebbp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .avail         (q_avail),
    .head          (queue_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .text_byte     (text_byte),
    .text_last     (text_last),
    .checksum_sum  (checksum_sum),
    .mfg_first     (mfg_first),
    .mfg_second    (mfg_second),
    .mfg_third     (mfg_third),
    .year          (year),
    .model_year    (model_year),
    .version_major (version_major),
    .version_minor (version_minor),
    .names_found   (names_found)
  );

endmodule

[test/ebbp_check_pkg.sv]
`timescale 1ns / 1ps
// Expected-result tracker for the EDID base block parser bench: per-byte decode
// of what the parser must emit, and in-order comparison of its results.
// Depends on ebbp_pkg for block layout constants and result kinds.
package ebbp_check_pkg;
  import ebbp_pkg::*;

  localparam int DescLen = 18;
  localparam logic [6:0] LetterBase = 7'd64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text;
    logic        last;
    logic [7:0]  sum;
    logic [6:0]  mfg1;
    logic [6:0]  mfg2;
    logic [6:0]  mfg3;
    logic [11:0] yr;
    logic        model_yr;
    logic [7:0]  vmajor;
    logic [7:0]  vminor;
    logic        names;
  } edid_result_t;

  class edid_decode_check;
    edid_result_t pending_results[$];
    int           mismatches;

    // Decoder state, reset values as after rst
    logic [6:0] pos;
    logic [7:0] byte_sum;
    logic [7:0] mfg_hi;
    logic [7:0] mfg_lo;
    logic [7:0] year_raw;
    logic       model_yr_flag;
    logic [7:0] major_raw;
    logic [7:0] minor_raw;
    logic       hdr_ok;
    logic       serial_slot;
    logic       text_on;
    logic [3:0] text_cnt;
    logic       model_hit;
    logic       serial_hit;

    function new();
      mismatches    = 0;
      pos           = '0;
      byte_sum      = '0;
      mfg_hi        = '0;
      mfg_lo        = '0;
      year_raw      = '0;
      model_yr_flag = 1'b0;
      major_raw     = '0;
      minor_raw     = '0;
      hdr_ok        = 1'b1;
      serial_slot   = 1'b0;
      text_on       = 1'b0;
      text_cnt      = '0;
      model_hit     = 1'b0;
      serial_hit    = 1'b0;
    endfunction

    // Advance the decoder by one transferred byte; queue any result it causes.
    function void take_byte(logic [7:0] b);
      edid_result_t r;
      logic [4:0]   off;
      bit           emit;
      r    = '0;
      emit = 1'b0;
      byte_sum += b;
      case (pos)
        PosMfgHi:   mfg_hi = b;
        PosMfgLo:   mfg_lo = b;
        PosModelYr: model_yr_flag = (b == ByteFF);
        PosYear:    year_raw = b;
        PosMajor:   major_raw = b;
        PosMinor:   minor_raw = b;
        default:    ;
      endcase
      if (pos >= PosDescLo && pos < PosDescEnd) begin
        off = 5'((int'(pos) - int'(PosDescLo)) % DescLen);
        if (off == OffHdr0) begin
          hdr_ok  = (b == 8'h00);
          text_on = 1'b0;
        end else if (off == OffHdr1 || off == OffHdr2) begin
          hdr_ok = hdr_ok && (b == 8'h00);
        end else if (off == OffTag) begin
          if (hdr_ok && (b == TagModel || b == TagSerial)) begin
            serial_slot = (b == TagSerial);
            text_on     = 1'b1;
            text_cnt    = '0;
            if (serial_slot) serial_hit = 1'b1;
            else model_hit = 1'b1;
          end else begin
            text_on = 1'b0;
          end
        end else if (off >= OffText && text_on) begin
          r.kind = serial_slot ? KindSerial : KindModel;
          if (b == TextTerm) begin
            r.last  = 1'b1;
            text_on = 1'b0;
          end else begin
            text_cnt += 1'b1;
            r.text = b;
            if (text_cnt >= TextMax) begin
              r.last  = 1'b1;
              text_on = 1'b0;
            end
          end
          emit = 1'b1;
        end
      end
      if (pos == PosLast) begin
        r          = '0;
        r.kind     = KindSummary;
        r.sum      = byte_sum;
        r.mfg1     = LetterBase + 7'(mfg_hi[6:2]);
        r.mfg2     = LetterBase + 7'({mfg_hi[1:0], mfg_lo[7:5]});
        r.mfg3     = LetterBase + 7'(mfg_lo[4:0]);
        r.yr       = 12'(year_raw) + YearBase;
        r.model_yr = model_yr_flag;
        r.vmajor   = major_raw;
        r.vminor   = minor_raw;
        r.names    = model_hit && serial_hit;
        emit       = 1'b1;
        byte_sum   = '0;
        model_hit  = 1'b0;
        serial_hit = 1'b0;
        text_on    = 1'b0;
      end
      pos += 1'b1;
      if (emit) pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    // Compare one transferred result with the oldest expectation.
    task match_result(edid_result_t got);
      edid_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result of kind %0d with nothing pending", got.kind));
        return;
      end
      want = pending_results.pop_front();
      check_field("result_kind", got.kind, want.kind);
      check_field("text_byte", got.text, want.text);
      check_field("text_last", got.last, want.last);
      check_field("checksum_sum", got.sum, want.sum);
      check_field("mfg_first", got.mfg1, want.mfg1);
      check_field("mfg_second", got.mfg2, want.mfg2);
      check_field("mfg_third", got.mfg3, want.mfg3);
      check_field("year", got.yr, want.yr);
      check_field("model_year", got.model_yr, want.model_yr);
      check_field("version_major", got.vmajor, want.vmajor);
      check_field("version_minor", got.vminor, want.vminor);
      check_field("names_found", got.names, want.names);
    endtask
  endclass

endpackage

[test/edid_base_block_parser_core_test.sv]
`timescale 1ns / 1ps
// Bench top for edid_base_block_parser_core: streams whole 128-byte base blocks
// with random gaps and result stalls. Depends on ebbp_pkg and ebbp_check_pkg.
module edid_base_block_parser_core_test;
  import ebbp_pkg::*;
  import ebbp_check_pkg::*;

  localparam int IdleLimit  = 4000;  // cycles with no transfer on either side
  localparam int IdlePct    = 31;    // percent of cycles each side idles
  localparam int HoldCycles = 250;   // long receiver hold-off to back up the block
  localparam int HoldAfter  = 25;    // results seen before the hold-off starts
  localparam int TailCycles = 20;    // drain time after the last expectation

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  edid_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  text_byte;
  logic        text_last;
  logic [7:0]  checksum_sum;
  logic [6:0]  mfg_first;
  logic [6:0]  mfg_second;
  logic [6:0]  mfg_third;
  logic [11:0] year;
  logic        model_year;
  logic [7:0]  version_major;
  logic [7:0]  version_minor;
  logic        names_found;

  edid_decode_check tracker = new();

  logic [7:0] block_buf [128];  // block being streamed
  bit         calm = 1'b0;      // no idling on either side while set
  int         results_seen = 0;
  int         hold_left = 0;
  int         idle_cycles = 0;

  always #5 clk = ~clk;

  edid_base_block_parser_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .edid_byte     (edid_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .text_byte     (text_byte),
    .text_last     (text_last),
    .checksum_sum  (checksum_sum),
    .mfg_first     (mfg_first),
    .mfg_second    (mfg_second),
    .mfg_third     (mfg_third),
    .year          (year),
    .model_year    (model_year),
    .version_major (version_major),
    .version_minor (version_minor),
    .names_found   (names_found)
  );

  // Offer one byte; optional idle cycles first, with valid low and junk on the
  // data lines. Returns at the edge where the transfer happens. Valid is never
  // dropped and re-raised in the same step.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < IdlePct) begin
      in_valid  <= 1'b0;
      edid_byte <= 8'($urandom);
      @(posedge clk);
      while (!calm && $urandom_range(99) < IdlePct) @(posedge clk);
    end
    in_valid  <= 1'b1;
    edid_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_byte(b);
  endtask

  task automatic send_block();
    for (int i = 0; i < 128; i++) send_byte(block_buf[i]);
  endtask

  // 00 00 00 <tag> 00 at the start of a descriptor
  task automatic set_header(input int base, input logic [7:0] tag);
    block_buf[base]     = 8'h00;
    block_buf[base + 1] = 8'h00;
    block_buf[base + 2] = 8'h00;
    block_buf[base + 3] = tag;
    block_buf[base + 4] = 8'h00;
  endtask

  // Last byte makes the 128-byte sum come out zero
  task automatic fix_checksum();
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 127; i++) acc += block_buf[i];
    block_buf[PosLast] = 8'(-acc);
  endtask

  // Random block: most descriptors carry well-formed text of random length and
  // content, some are near-miss headers (one bit off), the rest plain noise.
  task automatic fill_random_block();
    int         base;
    int         len;
    logic [7:0] tag;
    logic [7:0] c;
    foreach (block_buf[i]) block_buf[i] = 8'($urandom);
    for (int d = 0; d < 4; d++) begin
      base = int'(PosDescLo) + d * DescLen;
      tag  = $urandom_range(1) ? TagSerial : TagModel;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          set_header(base, tag);
          len = $urandom_range(13);
          for (int k = 0; k < len; k++) begin
            c = 8'($urandom);
            if (c == TextTerm) c = 8'h20;
            block_buf[base + int'(OffText) + k] = c;
          end
          // a short string gets its terminator; the rest of the slot is noise
          if (len < 13) block_buf[base + int'(OffText) + len] = TextTerm;
        end
        6, 7: begin
          set_header(base, tag);
          block_buf[base + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        end
        default: ;
      endcase
    end
    if ($urandom_range(1)) fix_checksum();
  endtask

  // Receiver: checks each result transfer, stalls at random, and once holds
  // off for a long stretch so the queue fills and in_ready drops.
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.match_result('{result_kind, text_byte, text_last, checksum_sum,
                               mfg_first, mfg_second, mfg_third, year, model_year,
                               version_major, version_minor, names_found});
        results_seen++;
        if (results_seen == HoldAfter) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int base;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Block A: extreme id bytes, valid checksum, both names present.
    // Model name ends on a terminator, serial runs the full 13 bytes (with
    // 00 and FF as text), a repeated model descriptor is terminator-only,
    // and the last descriptor has a broken header.
    foreach (block_buf[i]) block_buf[i] = 8'h00;
    for (int i = 1; i < 7; i++) block_buf[i] = 8'hFF;
    block_buf[PosMfgHi]   = 8'hFF;
    block_buf[PosMfgLo]   = 8'hFF;
    block_buf[PosModelYr] = ByteFF;
    block_buf[PosYear]    = 8'hFF;
    block_buf[PosMajor]   = 8'h01;
    block_buf[PosMinor]   = 8'hFF;
    base = int'(PosDescLo);
    set_header(base, TagModel);
    block_buf[base + 5] = "A";
    block_buf[base + 6] = "B";
    block_buf[base + 7] = "C";
    block_buf[base + 8] = TextTerm;
    base += DescLen;
    set_header(base, TagSerial);
    for (int k = 0; k < 13; k++) block_buf[base + 5 + k] = 8'(8'h21 + k * 19);
    block_buf[base + 7] = 8'h00;
    block_buf[base + 8] = 8'hFF;
    base += DescLen;
    set_header(base, TagModel);
    block_buf[base + 5] = TextTerm;
    base += DescLen;
    set_header(base, TagModel);
    block_buf[base + 2] = 8'h01;
    block_buf[base + 5] = "X";
    block_buf[base + 6] = "Y";
    fix_checksum();
    send_block();

    // Block B: zero id bytes, bad checksum, serial only; its terminator sits
    // in the last text slot, then a near-miss tag and two empty descriptors.
    foreach (block_buf[i]) block_buf[i] = 8'h00;
    base = int'(PosDescLo);
    set_header(base, TagSerial);
    for (int k = 0; k < 12; k++) block_buf[base + 5 + k] = 8'(8'h30 + k);
    block_buf[base + 17] = TextTerm;
    set_header(base + DescLen, 8'hFD);
    block_buf[PosLast] = 8'hFF;
    send_block();

    // Random blocks; one runs with no idling on either side
    for (int n = 0; n < 2; n++) begin
      calm = (n == 1);
      fill_random_block();
      send_block();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[edid_base_block_parser_core.f]
hdl/ebbp_pkg.sv
hdl/ebbp_front.sv
hdl/ebbp_queue.sv
hdl/ebbp_back.sv
hdl/edid_base_block_parser_core.sv
test/ebbp_check_pkg.sv
test/edid_base_block_parser_core_test.sv
